[rtl/psre_pkg.sv]
package psre_pkg;

  localparam int unsigned FREQ_MAX  = 250000;
  localparam int unsigned FREQ_MIN  = 200;
  localparam int unsigned TICK_HZ   = 1000000;
  localparam int unsigned DUTY_STEP = 100;
  localparam int unsigned LED_NUM   = 125000;
  localparam int unsigned RESET_FREQ = 250;

  localparam int unsigned ENTRY_W  = 18;
  localparam int unsigned DIVD_W   = 20;
  localparam int unsigned DIVS_W   = 18;
  localparam int unsigned PER_W    = 13;
  localparam int unsigned LEDP_W   = 17;
  localparam int unsigned RATE_W   = 10;
  localparam int unsigned DIV_STEPS = DIVD_W;
  localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

  localparam logic [7:0] CH_DELETE = 8'd127;
  localparam logic [7:0] CH_ENTER  = 8'd13;

  localparam logic [1:0] NOTE_NONE  = 2'd0;
  localparam logic [1:0] NOTE_CLAMP = 2'd1;
  localparam logic [1:0] NOTE_RAISE = 2'd2;

  localparam logic [2:0] ADDR_RATE_MIN = 3'd0;
  localparam logic [2:0] ADDR_RATE_MAX = 3'd4;

  localparam logic [PER_W-1:0]  RESET_PERIOD = PER_W'(TICK_HZ / RESET_FREQ);
  localparam logic [RATE_W-1:0] RESET_RATE_MIN = RATE_W'(1);
  localparam logic [RATE_W-1:0] RESET_RATE_MAX = RATE_W'(10);
  localparam logic [LEDP_W-1:0] RESET_LED_PERIOD = LEDP_W'(LED_NUM / 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    DK_NONE,
    DK_PERIOD,
    DK_LED,
    DK_ENTRY
  } div_kind_t;

  typedef enum logic [1:0] {
    MODE_CHAR,
    MODE_UP,
    MODE_DOWN,
    MODE_STOP
  } mode_t;

endpackage

[rtl/pwm_speed_ramp_and_entry.sv]
// Two-wheel PWM command unit. Each request on the slave stream carries a mode in s_tuser
// (character entry, speed up, slow down, stop) and a character byte in s_tdata, and gives
// exactly one result with the wheel period, both duties, the LED timer period and status
// flags. Enter, delete of a digit and every button event need a quotient, which comes from
// one shared restoring divider that retires one quotient bit per cycle; such a request
// passes through the divide state to the finish state, any other goes straight to finish.
// The next request is taken once the result sits in the output register, even while it
// waits for m_tready. The limits led_rate_min and led_rate_max are written over APB at
// byte addresses 0 and 4; the user must do this only while the unit is idle (not enforced).
module pwm_speed_ramp_and_entry
  import psre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] char_code
  input  logic [1:0]  s_tuser,  // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // [12:0] pwm_period, [25:13] duty_a, [38:26] duty_b, [55:39] led_period, [56] echo,
  // [58:57] note, [59] entry_done, [60] stopped, [63:61] zero
  output logic [63:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state, state_next;
  div_kind_t kind, kind_next;

  logic [RATE_W-1:0]  led_rate_min, led_rate_max;
  logic [ENTRY_W-1:0] entry_value, entry_next;
  logic [PER_W-1:0]   period_reg, duty_a_reg, duty_b_reg, duty_a_next, duty_b_next;
  logic [RATE_W-1:0]  led_rate, led_rate_next;
  logic [LEDP_W-1:0]  led_period_reg;
  logic               echo, echo_next, entry_done, done_next, stopped, stopped_next;
  logic [1:0]         note, note_next;

  logic [DIVD_W-1:0]  div_q, dividend_next;
  logic [DIVS_W-1:0]  div_r, div_d, divisor_next;
  logic [CNT_W-1:0]   div_cnt;
  logic [DIVS_W:0]    trial;
  logic               trial_ge;

  logic               in_accept, load_out, cfg_write;
  logic [21:0]        digit_sum;
  logic [PER_W:0]     sum_a, sum_b;
  logic [PER_W-1:0]   dn_a, dn_b;
  logic [PER_W-1:0]   period_fin;
  logic [LEDP_W-1:0]  led_fin;
  mode_t              mode;

  assign mode      = mode_t'(s_tuser);
  assign in_accept = s_tvalid && s_tready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2]) begin
      prdata[RATE_W-1:0] = led_rate_max;
    end else begin
      prdata[RATE_W-1:0] = led_rate_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_rate_min <= RESET_RATE_MIN;
      led_rate_max <= RESET_RATE_MAX;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        led_rate_max <= pwdata[RATE_W-1:0];
      end else begin
        led_rate_min <= pwdata[RATE_W-1:0];
      end
    end
  end

  // Decision for one request, taken in the cycle it is accepted.
  always_comb begin
    entry_next    = entry_value;
    duty_a_next   = duty_a_reg;
    duty_b_next   = duty_b_reg;
    led_rate_next = led_rate;
    echo_next     = 1'b0;
    note_next     = NOTE_NONE;
    done_next     = 1'b0;
    stopped_next  = 1'b0;
    kind_next     = DK_NONE;
    dividend_next = DIVD_W'(TICK_HZ);
    divisor_next  = DIVS_W'(FREQ_MIN);
    digit_sum     = {1'b0, entry_value, 3'b000} + {3'b000, entry_value, 1'b0}
                    + {18'd0, s_tdata[3:0]};
    sum_a         = {1'b0, duty_a_reg} + (PER_W + 1)'(DUTY_STEP);
    sum_b         = {1'b0, duty_b_reg} + (PER_W + 1)'(DUTY_STEP);
    dn_a          = (duty_a_reg >= PER_W'(DUTY_STEP)) ? duty_a_reg - PER_W'(DUTY_STEP)
                                                      : duty_a_reg;
    dn_b          = (duty_b_reg >= PER_W'(DUTY_STEP)) ? duty_b_reg - PER_W'(DUTY_STEP)
                                                      : duty_b_reg;
    unique case (mode)
      MODE_CHAR: begin
        if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
          if (digit_sum < 22'(FREQ_MAX)) begin
            entry_next = digit_sum[ENTRY_W-1:0];
            echo_next  = 1'b1;
          end else begin
            entry_next = ENTRY_W'(FREQ_MAX);
            note_next  = NOTE_CLAMP;
          end
        end else if (s_tdata == CH_DELETE) begin
          if (entry_value != '0) begin
            echo_next     = 1'b1;
            kind_next     = DK_ENTRY;
            dividend_next = DIVD_W'(entry_value);
            divisor_next  = DIVS_W'(10);
          end
        end else if (s_tdata == CH_ENTER) begin
          kind_next  = DK_PERIOD;
          done_next  = 1'b1;
          entry_next = '0;
          if (entry_value < ENTRY_W'(FREQ_MIN)) begin
            note_next    = NOTE_RAISE;
            divisor_next = DIVS_W'(FREQ_MIN);
          end else begin
            divisor_next = DIVS_W'(entry_value);
          end
        end
      end
      MODE_UP: begin
        kind_next = DK_LED;
        if (led_rate < led_rate_max) begin
          led_rate_next = led_rate + RATE_W'(1);
        end
        if (duty_a_reg < period_reg && duty_b_reg < period_reg) begin
          duty_a_next = sum_a[PER_W] ? {PER_W{1'b1}} : sum_a[PER_W-1:0];
          duty_b_next = sum_b[PER_W] ? {PER_W{1'b1}} : sum_b[PER_W-1:0];
        end else begin
          duty_a_next = period_reg;
          duty_b_next = period_reg;
        end
      end
      MODE_DOWN: begin
        kind_next = DK_LED;
        if (dn_a < PER_W'(DUTY_STEP) && dn_b < PER_W'(DUTY_STEP)) begin
          duty_a_next   = '0;
          duty_b_next   = '0;
          led_rate_next = led_rate_min;
          stopped_next  = 1'b1;
        end else begin
          duty_a_next = dn_a;
          duty_b_next = dn_b;
          if (led_rate_min < led_rate) begin
            led_rate_next = led_rate - RATE_W'(1);
          end
        end
      end
      MODE_STOP: begin
        kind_next     = DK_LED;
        duty_a_next   = '0;
        duty_b_next   = '0;
        led_rate_next = led_rate_min;
      end
      default: begin
        kind_next = DK_NONE;
      end
    endcase
    if (kind_next == DK_LED) begin
      dividend_next = DIVD_W'(LED_NUM);
      divisor_next  = (led_rate_next == '0) ? DIVS_W'(1) : DIVS_W'(led_rate_next);
    end
  end

  assign trial    = {div_r, div_q[DIVD_W-1]};
  assign trial_ge = trial >= {1'b0, div_d};

  always_comb begin
    period_fin = period_reg;
    led_fin    = led_period_reg;
    if (kind == DK_PERIOD) begin
      period_fin = (div_q[DIVD_W-1:PER_W] != '0) ? {PER_W{1'b1}} : div_q[PER_W-1:0];
    end
    if (kind == DK_LED) begin
      led_fin = div_q[LEDP_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (kind_next == DK_NONE) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DIV:  s_tready = 1'b0;
      ST_FIN:  load_out = !m_tvalid || m_tready;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      kind           <= DK_NONE;
      m_tvalid       <= 1'b0;
      entry_value    <= '0;
      period_reg     <= RESET_PERIOD;
      duty_a_reg     <= '0;
      duty_b_reg     <= '0;
      led_rate       <= RESET_RATE_MIN;
      led_period_reg <= RESET_LED_PERIOD;
      div_cnt        <= '0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        kind        <= kind_next;
        entry_value <= entry_next;
        duty_a_reg  <= duty_a_next;
        duty_b_reg  <= duty_b_next;
        led_rate    <= led_rate_next;
        div_cnt     <= '0;
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt + CNT_W'(1);
      end
      if (load_out) begin
        m_tvalid       <= 1'b1;
        period_reg     <= period_fin;
        led_period_reg <= led_fin;
        if (kind == DK_ENTRY) begin
          entry_value <= div_q[ENTRY_W-1:0];
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      echo       <= echo_next;
      note       <= note_next;
      entry_done <= done_next;
      stopped    <= stopped_next;
      div_q      <= dividend_next;
      div_d      <= divisor_next;
      div_r      <= '0;
    end else if (state == ST_DIV) begin
      div_q <= {div_q[DIVD_W-2:0], trial_ge};
      div_r <= trial_ge ? DIVS_W'(trial - {1'b0, div_d}) : trial[DIVS_W-1:0];
    end
    if (load_out) begin
      m_tdata <= {3'b000, stopped, entry_done, note, echo, led_fin, duty_b_reg, duty_a_reg,
                  period_fin};
    end
  end

`ifndef SYNTH
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FIN)
    else $error("result loaded outside the finish step");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("second request taken while one is in flight");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && mode == MODE_STOP |=> duty_a_reg == '0 && duty_b_reg == '0)
    else $error("stop left a nonzero duty");

  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    entry_value <= ENTRY_W'(FREQ_MAX))
    else $error("entry value above the frequency limit");
`endif

endmodule

[dv/pwm_speed_ramp_and_entry_tb.sv]
`timescale 1ns / 1ps

module pwm_speed_ramp_and_entry_tb;
  import psre_pkg::*;

  typedef struct packed {
    logic [2:0]  pad;
    logic        stopped;
    logic        entry_done;
    logic [1:0]  note;
    logic        echo;
    logic [16:0] led_period;
    logic [12:0] duty_b;
    logic [12:0] duty_a;
    logic [12:0] pwm_period;
  } wheel_status_t;

  typedef struct {
    mode_t      mode;
    logic [7:0] char_code;
  } command_t;

  localparam logic [7:0]  CH_ZERO      = 8'h30;
  localparam logic [7:0]  CH_NINE      = 8'h39;
  localparam int unsigned IDLE_MAX     = 13;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 72;
  localparam int unsigned PRINT_MAX    = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pwm_speed_ramp_and_entry i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [21:0] entry_acc;
  logic [12:0] period_now;
  logic [12:0] duty_a_now;
  logic [12:0] duty_b_now;
  logic [9:0]  rate_now;
  logic [9:0]  rate_lo;
  logic [9:0]  rate_hi;
  logic [16:0] led_period_now;

  command_t      pending_cmds[$];
  wheel_status_t expected_status[$];
  command_t      cur_cmd;

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_armed = 1'b0;
  bit          hold_used = 1'b0;
  int unsigned tx_gap;
  int unsigned rx_stall;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned n_queued;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_cfg;
  int unsigned n_errors;

  function automatic logic [12:0] period_for(int unsigned freq);
    int unsigned p;
    if (freq == 0) freq = 1;
    p = TICK_HZ / freq;
    return (p > 32'h1FFF) ? 13'h1FFF : p[12:0];
  endfunction

  function automatic void set_rate(logic [9:0] rate);
    rate_now = rate;
    led_period_now = 17'(LED_NUM / ((rate == 0) ? 1 : rate));
  endfunction

  function automatic logic [12:0] duty_raise(logic [12:0] d);
    int unsigned v;
    v = d + DUTY_STEP;
    return (v > 32'h1FFF) ? 13'h1FFF : v[12:0];
  endfunction

  function automatic wheel_status_t predict_status(command_t c);
    wheel_status_t r;
    int unsigned   v;
    r = '0;
    case (c.mode)
      MODE_CHAR: begin
        if (c.char_code >= CH_ZERO && c.char_code <= CH_NINE) begin
          v = entry_acc * 10 + (c.char_code & 8'h0F);
          if (v < FREQ_MAX) begin
            entry_acc = v[21:0];
            r.echo = 1'b1;
          end else begin
            entry_acc = 22'(FREQ_MAX);
            r.note = NOTE_CLAMP;
          end
        end else if (c.char_code == CH_DELETE) begin
          if (entry_acc != 0) begin
            entry_acc = 22'(entry_acc / 10);
            r.echo = 1'b1;
          end
        end else if (c.char_code == CH_ENTER) begin
          v = 32'(entry_acc);
          if (v < FREQ_MIN) begin
            v = FREQ_MIN;
            r.note = NOTE_RAISE;
          end
          period_now = period_for(v);
          entry_acc = '0;
          r.entry_done = 1'b1;
        end
      end
      MODE_UP: begin
        if (rate_now < rate_hi) set_rate(rate_now + 10'd1);
        if (duty_a_now < period_now && duty_b_now < period_now) begin
          duty_a_now = duty_raise(duty_a_now);
          duty_b_now = duty_raise(duty_b_now);
        end else begin
          duty_a_now = period_now;
          duty_b_now = period_now;
        end
      end
      MODE_DOWN: begin
        if (rate_lo < rate_now) set_rate(rate_now - 10'd1);
        if (duty_a_now >= DUTY_STEP) duty_a_now = 13'(duty_a_now - DUTY_STEP);
        if (duty_b_now >= DUTY_STEP) duty_b_now = 13'(duty_b_now - DUTY_STEP);
        if (duty_a_now < DUTY_STEP && duty_b_now < DUTY_STEP) begin
          duty_a_now = '0;
          duty_b_now = '0;
          set_rate(rate_lo);
          r.stopped = 1'b1;
        end
      end
      default: begin
        duty_a_now = '0;
        duty_b_now = '0;
        set_rate(rate_lo);
      end
    endcase
    r.pwm_period = period_now;
    r.duty_a = duty_a_now;
    r.duty_b = duty_b_now;
    r.led_period = led_period_now;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    n_errors++;
    if (n_errors <= PRINT_MAX)
      $display("%0t: result %0d %s: got %0h, expected %0h", $realtime, n_checked, what, got,
               want);
  endtask

  task automatic check_field(string what, longint unsigned got, longint unsigned want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : drive_requests
    int unsigned gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else if (s_tvalid && s_tready) begin
      expected_status.push_back(predict_status(cur_cmd));
      n_sent++;
      gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap == 0 && pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        s_tdata <= cur_cmd.char_code;
        s_tuser <= cur_cmd.mode;
      end else begin
        s_tvalid <= 1'b0;
        tx_gap <= gap;
      end
    end else if (!s_tvalid) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
      end else if (pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        s_tdata <= cur_cmd.char_code;
        s_tuser <= cur_cmd.mode;
        s_tvalid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    wheel_status_t got;
    wheel_status_t want;
    int unsigned   stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_status.size() == 0) begin
          report_mismatch("result with no request pending", m_tdata, 0);
        end else begin
          want = expected_status.pop_front();
          check_field("pwm_period", got.pwm_period, want.pwm_period);
          check_field("duty_a", got.duty_a, want.duty_a);
          check_field("duty_b", got.duty_b, want.duty_b);
          check_field("led_period", got.led_period, want.led_period);
          check_field("echo", got.echo, want.echo);
          check_field("note", got.note, want.note);
          check_field("entry_done", got.entry_done, want.entry_done);
          check_field("stopped", got.stopped, want.stopped);
          check_field("padding", got.pad, want.pad);
        end
        n_checked++;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        stall = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (stall != 0) begin
          m_tready <= 1'b0;
          rx_stall <= stall;
        end
      end else if (!m_tready) begin
        if (rx_stall != 0) rx_stall <= rx_stall - 1;
        else m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", quiet_cycles);
      $display("pwm_speed_ramp_and_entry_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cmd(mode_t m, logic [7:0] ch);
    command_t c;
    c.mode = m;
    c.char_code = ch;
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  task automatic wait_drained(int unsigned extra);
    while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
      @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_limit(logic [2:0] addr, logic [9:0] value);
    logic [31:0] word;
    word = $urandom();
    word[9:0] = value;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_RATE_MIN) rate_lo = value;
    else rate_hi = value;
    n_cfg++;
  endtask

  task automatic queue_entry();
    int unsigned ndig;
    ndig = $urandom_range(1, 7);
    for (int i = 0; i < ndig; i++) begin
      push_cmd(MODE_CHAR, CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 7) == 0) push_cmd(MODE_CHAR, CH_DELETE);
    end
    if ($urandom_range(0, 7) != 0) push_cmd(MODE_CHAR, CH_ENTER);
  endtask

  task automatic queue_buttons();
    int unsigned ups;
    int unsigned downs;
    ups = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    repeat (ups) push_cmd(MODE_UP, 8'($urandom()));
    downs = $urandom_range(0, ups + 2);
    repeat (downs) push_cmd(MODE_DOWN, 8'($urandom()));
    if ($urandom_range(0, 3) == 0) push_cmd(MODE_STOP, 8'($urandom()));
  endtask

  initial begin
    int unsigned lo_tab[PHASES] = '{1, 1, 1000, 0, 5, 1023, 1, 0, 0, 0};
    int unsigned hi_tab[PHASES] = '{10, 1000, 1000, 3, 2, 1023, 1, 0, 0, 0};
    int unsigned lo;
    int unsigned hi;
    int unsigned start;
    int unsigned pick;

    rate_lo = RESET_RATE_MIN;
    rate_hi = RESET_RATE_MAX;
    entry_acc = '0;
    period_now = period_for(RESET_FREQ);
    duty_a_now = '0;
    duty_b_now = '0;
    set_rate(rate_lo);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_cmd(MODE_CHAR, CH_ZERO);
    push_cmd(MODE_CHAR, CH_DELETE);
    push_cmd(MODE_CHAR, CH_ZERO + 8'd5);
    push_cmd(MODE_CHAR, CH_ZERO);
    push_cmd(MODE_CHAR, CH_ZERO);
    push_cmd(MODE_CHAR, CH_ENTER);
    push_cmd(MODE_CHAR, CH_ENTER);
    push_cmd(MODE_UP, 8'hFF);
    push_cmd(MODE_UP, 8'h00);
    push_cmd(MODE_DOWN, 8'hFF);
    push_cmd(MODE_DOWN, 8'h00);
    push_cmd(MODE_STOP, 8'hFF);
    repeat (6) push_cmd(MODE_CHAR, CH_NINE);
    push_cmd(MODE_CHAR, CH_DELETE);
    push_cmd(MODE_CHAR, CH_ZERO - 8'd1);
    push_cmd(MODE_CHAR, CH_NINE + 8'd1);
    push_cmd(MODE_CHAR, CH_ENTER);
    push_cmd(MODE_UP, 8'h55);
    push_cmd(MODE_UP, 8'hAA);
    push_cmd(MODE_STOP, 8'h00);
    wait_drained(4);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        if (phase >= 7) begin
          lo = $urandom_range(1, 1000);
          hi = $urandom_range(lo, 1000);
        end else begin
          lo = lo_tab[phase];
          hi = hi_tab[phase];
        end
        write_limit(ADDR_RATE_MIN, 10'(lo));
        write_limit(ADDR_RATE_MAX, 10'(hi));
        @(negedge clk);
      end
      tx_idle_on <= (phase != 5);
      rx_idle_on <= (phase != 5);
      start = n_queued;
      while (n_queued - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) queue_entry();
        else if (pick < 8) queue_buttons();
        else push_cmd(mode_t'($urandom_range(0, 3)), 8'($urandom()));
      end
      if (phase == 1) hold_armed <= 1'b1;
      wait_drained(4);
    end

    wait_drained(DRAIN_CYCLES);
    while (expected_status.size() != 0) begin
      void'(expected_status.pop_front());
      report_mismatch("result never arrived", 0, 1);
    end

    $display("Checked %0d results for %0d requests across %0d limit writes,", n_checked,
             n_sent, n_cfg);
    $display("including digit entry, clamp and raise, ramps, stops and a long output stall.");
    if (n_errors == 0) begin
      $display("pwm_speed_ramp_and_entry_tb passed");
    end else begin
      $display("pwm_speed_ramp_and_entry_tb failed");
    end
    $finish;
  end

endmodule
